// ===== sv/fpa_pkg.sv =====
`default_nettype none
package fpa_pkg;
	localparam int FRAC_BITS_DEF = 8;
	localparam int WORD_BITS_DEF = 32;
	// quotient bits resolved per divider stage
	localparam int DIV_STEPS = 4;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
		OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
		OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_OVF = 2'd1, ST_DIV0 = 2'd2
	} status_t;
endpackage
`default_nettype wire

// ===== sv/fixed_point_alu_q24_8.sv =====
// fixed_point_alu_q24_8: signed fixed-point alu, raw words with FRAC_BITS
// fraction bits.
// input channel s_axis: tdata = {b_raw, a_raw}, tuser = op code. one request
// in gives exactly one request out on m_axis (tdata = {status,
// compare_true, result_raw} padded to bytes).
// every op runs down one pipeline; divide sets the depth: a restoring
// divider with four quotient bits per stage, ceil((WORD_BITS+FRAC_BITS)/4)
// stages (10 at the defaults), plus one decode stage and the output register.
// throughput: one request per cycle, sustained while the receiver does not stall.
// when the receiver stalls with the output register full, the whole pipe
// holds (s_axis_tready low) and nothing is lost or repeated; while the
// output register is empty or being drained the pipe moves.
// reset (arst_n low) clears all valid bits; payload registers are not reset.
// multiply and divide round to nearest with ties away from zero, to-int
// floors; overflow saturates with status 1, divide by zero status 2.
`default_nettype none
module fixed_point_alu_q24_8 import fpa_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [63:0] s_axis_tdata,   // a_raw[31:0], b_raw[63:32]
	input  wire  [3:0]  s_axis_tuser,   // op
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata    // result_raw[31:0], compare_true[32], status[34:33]
);
	localparam int W = WORD_BITS;
	localparam int PB = W + FRAC_BITS;  // widened magnitude bits
	// sideband through divider: op(4) | res(W) | cmp | ovf
	localparam int SB = 4 + W + 2;

	logic en;
	logic m_valid_q;
	assign en = !m_valid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = m_valid_q;

	// sign-extend or wrap 32-bit fields into W bits
	logic signed [W-1:0] a_w, b_w;
	always_comb begin
		logic signed [31:0] a32, b32;
		a32 = s_axis_tdata[31:0];
		b32 = s_axis_tdata[63:32];
		if (W >= 32) begin
			a_w = W'(a32);
			b_w = W'(b32);
		end else begin
			a_w = a32[W-1:0];
			b_w = b32[W-1:0];
		end
	end

	// stage 1: decode; add/sub/inc/dec, compares, shifts, mag for mul/div
	logic [W-1:0] maxmag;
	assign maxmag = {1'b0, {(W-1){1'b1}}};

	op_t                 op_c;
	logic [W-1:0]        res_c;
	logic                cmp_c, ovf_c;
	logic signed [W-1:0] rhs;
	logic signed [W:0]   sum;
	logic [W-1:0]        ma, mb;
	logic [PB-1:0]       fi;
	always_comb begin
		op_c = op_t'(s_axis_tuser);
		ma = a_w[W-1] ? -a_w : a_w;
		mb = b_w[W-1] ? -b_w : b_w;
		res_c = '0;
		cmp_c = 1'b0;
		ovf_c = 1'b0;
		case (op_c)
			OP_SUB:  rhs = b_w;
			OP_INC:  rhs = W'(1);
			OP_DEC:  rhs = W'(1);
			default: rhs = b_w;
		endcase
		if (op_c == OP_SUB || op_c == OP_DEC) begin
			sum = {a_w[W-1], a_w} - {rhs[W-1], rhs};
		end else begin
			sum = {a_w[W-1], a_w} + {rhs[W-1], rhs};
		end
		fi = {{FRAC_BITS{1'b0}}, ma} << FRAC_BITS;
		case (op_c)
			OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
				if (sum[W] != sum[W-1]) begin
					ovf_c = 1'b1;
					res_c = sum[W] ? ~maxmag : maxmag;
				end else begin
					res_c = sum[W-1:0];
				end
			end
			// divide by zero answer, used only when b is zero
			OP_DIV: res_c = (a_w == '0) ? '0 : (a_w[W-1] ? ~maxmag : maxmag);
			OP_GT:  cmp_c = a_w > b_w;
			OP_LT:  cmp_c = a_w < b_w;
			OP_GE:  cmp_c = a_w >= b_w;
			OP_LE:  cmp_c = a_w <= b_w;
			OP_EQ:  cmp_c = a_w == b_w;
			OP_NE:  cmp_c = a_w != b_w;
			OP_MIN: res_c = (b_w < a_w) ? b_w : a_w;
			OP_MAX: res_c = (a_w < b_w) ? b_w : a_w;
			OP_FROM_INT: begin
				if (!a_w[W-1] && fi > PB'(maxmag)) begin
					ovf_c = 1'b1;
					res_c = maxmag;
				end else if (a_w[W-1] && fi > PB'(maxmag) + PB'(1)) begin
					ovf_c = 1'b1;
					res_c = ~maxmag;
				end else begin
					res_c = a_w[W-1] ? -fi[W-1:0] : fi[W-1:0];
				end
			end
			OP_TO_INT: res_c = W'(a_w >>> FRAC_BITS);
			default:   res_c = '0;
		endcase
	end

	logic          v_s1, neg_s1, z_s1;
	logic [W-1:0]  ma_s1, mb_s1;
	logic [SB-1:0] sb_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a_w[W-1] ^ b_w[W-1];
			z_s1   <= (op_c == OP_DIV) && (b_w == '0);
			ma_s1  <= ma;
			mb_s1  <= mb;
			sb_s1  <= {s_axis_tuser, res_c, cmp_c, ovf_c};
		end
	end

	// stage 2: multiply magnitudes (registered), runs beside the divider head
	logic [2*W-1:0] prod_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= ma_s1 * mb_s1;
		end
	end

	// divider; mul result is picked up at its second stage via delay line
	logic          dv;
	logic [W-1:0]  dres;
	logic          dovf, dz;
	logic [SB-1:0] dsb;
	fpa_div #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(W), .SB_BITS(SB)) u_div (
		.clk, .arst_n, .en,
		.in_valid(v_s1), .in_neg(neg_s1), .in_div0(z_s1),
		.in_num(ma_s1), .in_den(mb_s1), .in_sb(sb_s1),
		.out_valid(dv), .out_res(dres), .out_ovf(dovf), .out_div0(dz), .out_sb(dsb)
	);

	logic sb_s2_neg;
	always_ff @(posedge clk) begin
		if (en) begin
			sb_s2_neg <= neg_s1;
		end
	end

	// mul stage 3: round, shift, saturate; then delay to match divider depth
	localparam int NST = (PB + DIV_STEPS - 1) / DIV_STEPS;
	logic [W-1:0] mres_s3;
	logic         movf_s3;
	always_ff @(posedge clk) begin
		logic [2*W:0] r;
		logic         ng;
		if (en) begin
			r = ({1'b0, prod_s2} + (2*W+1)'(1 << (FRAC_BITS-1))) >> FRAC_BITS;
			ng = sb_s2_neg;
			movf_s3 <= 1'b0;
			if (!ng) begin
				if (r > (2*W+1)'(maxmag)) begin
					movf_s3 <= 1'b1;
					mres_s3 <= maxmag;
				end else begin
					mres_s3 <= r[W-1:0];
				end
			end else begin
				if (r > (2*W+1)'(maxmag) + (2*W+1)'(1)) begin
					movf_s3 <= 1'b1;
					mres_s3 <= ~maxmag;
				end else begin
					mres_s3 <= '0 - r[W-1:0];
				end
			end
		end
	end

	// delay line for mul result: NST stages in divider vs 2 used here
	localparam int MD = (NST > 2) ? NST - 2 : 1;
	logic [W:0] mdl_q [MD+1];
	assign mdl_q[0] = {movf_s3, mres_s3};
	for (genvar i = 0; i < MD; i++) begin : g_md
		always_ff @(posedge clk) begin
			if (en) begin
				mdl_q[i+1] <= mdl_q[i];
			end
		end
	end

	// output register
	op_t          oop;
	logic [W-1:0] ores;
	logic         ocmp;
	status_t      ost;
	logic [W:0]   mfin;
	always_comb begin
		oop  = op_t'(dsb[SB-1 -: 4]);
		mfin = mdl_q[MD];
		ores = dsb[W+1:2];
		ocmp = dsb[1];
		ost  = dsb[0] ? ST_OVF : ST_OK;
		case (oop)
			OP_MUL: begin
				ores = mfin[W-1:0];
				ost  = mfin[W] ? ST_OVF : ST_OK;
			end
			OP_DIV: begin
				ores = dz ? dsb[W+1:2] : dres;
				ost  = dz ? ST_DIV0 : (dovf ? ST_OVF : ST_OK);
			end
			default: ;
		endcase
	end

	logic [31:0] res32;
	always_comb begin
		if (W >= 32) begin
			res32 = ores[31:0];
		end else begin
			res32 = 32'(signed'(ores));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (en) begin
			m_valid_q <= dv;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {5'b0, ost, ocmp, res32};
		end
	end
endmodule
`default_nettype wire

// ===== sv/fpa_div.sv =====
`default_nettype none
// pipelined restoring divider, DIV_STEPS quotient bits per stage, rounding and
// saturation at the end; sideband payload rides along
module fpa_div import fpa_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int SB_BITS   = 1
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  in_valid,
	input  wire                  in_neg,
	input  wire                  in_div0,
	input  wire [WORD_BITS-1:0]  in_num,   // magnitude of a
	input  wire [WORD_BITS-1:0]  in_den,   // magnitude of b
	input  wire [SB_BITS-1:0]    in_sb,
	output logic                 out_valid,
	output logic [WORD_BITS-1:0] out_res,
	output logic                 out_ovf,
	output logic                 out_div0,
	output logic [SB_BITS-1:0]   out_sb
);
	localparam int NB = WORD_BITS + FRAC_BITS;   // numerator bits
	localparam int NST = (NB + DIV_STEPS - 1) / DIV_STEPS;
	localparam int RB = WORD_BITS + 1;            // remainder bits

	logic          v_q   [NST+1];
	logic          neg_q [NST+1];
	logic          z_q   [NST+1];
	logic [NB-1:0] num_q [NST+1];   // shifts left, quotient fills in from bottom
	logic [RB-1:0] rem_q [NST+1];
	logic [WORD_BITS-1:0] den_q [NST+1];
	logic [SB_BITS-1:0]   sb_q  [NST+1];

	always_comb begin
		v_q[0]   = in_valid;
		neg_q[0] = in_neg;
		z_q[0]   = in_div0;
		num_q[0] = {in_num, {FRAC_BITS{1'b0}}};
		rem_q[0] = '0;
		den_q[0] = in_den;
		sb_q[0]  = in_sb;
	end

	for (genvar s = 0; s < NST; s++) begin : g_st
		logic [NB-1:0] n_n;
		logic [RB-1:0] r_n;
		always_comb begin
			logic [RB-1:0] t;
			n_n = num_q[s];
			r_n = rem_q[s];
			for (int k = 0; k < DIV_STEPS; k++) begin
				if (s * DIV_STEPS + k < NB) begin
					t = {r_n[RB-2:0], n_n[NB-1]};
					n_n = {n_n[NB-2:0], 1'b0};
					if (t >= {1'b0, den_q[s]}) begin
						t = t - {1'b0, den_q[s]};
						n_n[0] = 1'b1;
					end
					r_n = t;
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[s+1] <= 1'b0;
			end else if (en) begin
				v_q[s+1] <= v_q[s];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				neg_q[s+1] <= neg_q[s];
				z_q[s+1]   <= z_q[s];
				num_q[s+1] <= n_n;
				rem_q[s+1] <= r_n;
				den_q[s+1] <= den_q[s];
				sb_q[s+1]  <= sb_q[s];
			end
		end
	end

	// round half away: 2r >= d
	logic [NB:0]          q_rnd;
	logic [WORD_BITS-1:0] maxmag;
	always_comb begin
		maxmag = {1'b0, {(WORD_BITS-1){1'b1}}};
		q_rnd = {1'b0, num_q[NST]} +
			(({rem_q[NST], 1'b0} >= {2'b0, den_q[NST]}) ? (NB+1)'(1) : '0);
		out_valid = v_q[NST];
		out_sb    = sb_q[NST];
		out_div0  = z_q[NST];
		out_ovf   = 1'b0;
		if (z_q[NST]) begin
			out_res = '0;
		end else if (!neg_q[NST]) begin
			if (q_rnd > (NB+1)'(maxmag)) begin
				out_ovf = 1'b1;
				out_res = maxmag;
			end else begin
				out_res = q_rnd[WORD_BITS-1:0];
			end
		end else begin
			if (q_rnd > (NB+1)'(maxmag) + (NB+1)'(1)) begin
				out_ovf = 1'b1;
				out_res = ~maxmag;
			end else begin
				out_res = '0 - q_rnd[WORD_BITS-1:0];
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/fpa_checker.sv =====
`default_nettype none
module fpa_checker import fpa_pkg::*; (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [39:0] m_axis_tdata
);
	// stalled output holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed under stall");
	// status never takes the unused code
	a_st: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[34:33] != 2'd3)
		else $error("bad status");
	// compare flag only with zero result and ok status
	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0
			&& m_axis_tdata[34:33] == ST_OK)
		else $error("compare with result");
	// input side ready whenever output is free
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("stall without full output");
endmodule

bind fixed_point_alu_q24_8 fpa_checker u_chk (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready,
	.m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top import fpa_pkg::*; ();

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int LATENCY = 12;
	localparam int IDLE_LIMIT = 2000;
	localparam int N_RANDOM = 1750;

	typedef struct packed {
		logic [1:0]  status;
		logic        cmp;
		logic [31:0] res;
	} alu_out_t;

	// one row of the directed table; check_exp asks for the typed-in result
	typedef struct {
		op_t         op;
		logic [31:0] a;
		logic [31:0] b;
		bit          check_exp;
		alu_out_t    exp_out;
	} vec_t;

	localparam logic [31:0] WMAX = 32'h7fff_ffff;
	localparam logic [31:0] WMIN = 32'h8000_0000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic [3:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;

	fixed_point_alu_q24_8 DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	alu_out_t    pending_results[$];
	int unsigned errors = 0;
	int unsigned n_sent = 0;
	int unsigned n_recv = 0;
	int unsigned idle_cycles = 0;
	bit          stim_done = 0;
	bit          timed_out = 0;
	int unsigned op_count[16];

	// clamp sign plus magnitude into the 32-bit range
	function automatic logic [31:0] clamp_mag(bit neg, logic [127:0] m, ref logic [1:0] st);
		if (!neg) begin
			if (m > 128'h7fff_ffff) begin
				st = ST_OVF;
				return WMAX;
			end
			return m[31:0];
		end
		if (m > 128'h8000_0000) begin
			st = ST_OVF;
			return WMIN;
		end
		return 32'd0 - m[31:0];
	endfunction

	function automatic alu_out_t alu_predict(op_t op, logic signed [31:0] a,
			logic signed [31:0] b);
		alu_out_t     r;
		logic [1:0]   st;
		logic signed [63:0] s;
		logic [63:0]  ma, mb;
		logic [127:0] p, q, rem;
		bit           neg;
		st = ST_OK;
		r = '0;
		ma = a < 0 ? -64'(a) : 64'(a);
		mb = b < 0 ? -64'(b) : 64'(b);
		neg = (a < 0) != (b < 0);
		case (op)
			OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
				case (op)
					OP_ADD:  s = 64'(a) + 64'(b);
					OP_SUB:  s = 64'(a) - 64'(b);
					OP_INC:  s = 64'(a) + 1;
					default: s = 64'(a) - 1;
				endcase
				r.res = clamp_mag(s < 0, s < 0 ? 128'(-s) : 128'(s), st);
			end
			OP_MUL: begin
				p = 128'(ma) * 128'(mb) + (128'd1 << (FRAC - 1));
				r.res = clamp_mag(neg, p >> FRAC, st);
			end
			OP_DIV: begin
				if (b == 0) begin
					st = ST_DIV0;
					r.res = a == 0 ? 32'd0 : (a < 0 ? WMIN : WMAX);
				end else begin
					q = (128'(ma) << FRAC) / 128'(mb);
					rem = (128'(ma) << FRAC) % 128'(mb);
					// round half away from zero
					if (2 * rem >= 128'(mb))
						q = q + 1;
					r.res = clamp_mag(neg, q, st);
				end
			end
			OP_GT: r.cmp = a > b;
			OP_LT: r.cmp = a < b;
			OP_GE: r.cmp = a >= b;
			OP_LE: r.cmp = a <= b;
			OP_EQ: r.cmp = a == b;
			OP_NE: r.cmp = a != b;
			OP_MIN: r.res = b < a ? b : a;
			OP_MAX: r.res = a < b ? b : a;
			OP_FROM_INT: r.res = clamp_mag(a < 0, 128'(ma) << FRAC, st);
			default: r.res = a >>> FRAC;
		endcase
		r.status = st;
		return r;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return WMAX;
			1: return WMIN;
			2: return 32'($signed($urandom_range(0, 2048)) - 1024);
			3: return 32'($urandom_range(0, 600)) << FRAC;
			4: return $urandom() >> $urandom_range(0, 31);
			5: return -($urandom() >> $urandom_range(8, 31));
			default: return $urandom();
		endcase
	endfunction

	vec_t directed[$];
	vec_t cur;

	// sender: bursts with random gaps
	int unsigned burst_left = 0;

	task automatic send_request(op_t op, logic [31:0] a, logic [31:0] b);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {b, a};
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		burst_left--;
		op_count[op]++;
	endtask

	// record the expectation when the request is accepted
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			if (n_sent < directed.size() && directed[n_sent].check_exp)
				pending_results.push_back(directed[n_sent].exp_out);
			else
				pending_results.push_back(alu_predict(op_t'(s_axis_tuser),
					s_axis_tdata[31:0], s_axis_tdata[63:32]));
			n_sent++;
		end
	end

	// receiver: stalls on a slowly changing pattern, with quiet stretches
	logic [15:0] stall_lfsr;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_lfsr <= 16'hace1;
			m_axis_tready <= 1'b0;
		end else begin
			stall_lfsr <= {stall_lfsr[14:0], stall_lfsr[15] ^ stall_lfsr[13]
				^ stall_lfsr[12] ^ stall_lfsr[10]};
			m_axis_tready <= stall_lfsr[15] ? 1'b1 : (stall_lfsr[3:0] != 4'd0);
		end
	end

	// check each result against the oldest expectation
	always @(posedge clk) begin
		alu_out_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[34:0];
			n_recv++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected request out, actual %h", $time, got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.res !== want.res) begin
					$display("%0t: result_raw expected %h actual %h", $time, want.res,
						got.res);
					errors++;
				end
				if (got.cmp !== want.cmp) begin
					$display("%0t: compare_true expected %b actual %b", $time, want.cmp,
						got.cmp);
					errors++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						got.status);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles without any accepted request
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (stim_done && pending_results.size() == 0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("timeout at %0t", $time);
			$display("FAIL");
			$finish;
		end
	end

	function automatic vec_t row(op_t op, logic [31:0] a, logic [31:0] b, bit chk = 0,
			logic [31:0] res = 0, logic cmp = 0, logic [1:0] st = ST_OK);
		vec_t v;
		v.op = op;
		v.a = a;
		v.b = b;
		v.check_exp = chk;
		v.exp_out = '{status: st, cmp: cmp, res: res};
		return v;
	endfunction

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		// extremes, saturation and divide by zero typed in
		directed.push_back(row(OP_ADD, WMAX, 32'd1, 1, WMAX, 0, ST_OVF));
		directed.push_back(row(OP_SUB, WMIN, 32'd1, 1, WMIN, 0, ST_OVF));
		directed.push_back(row(OP_SUB, 32'd0, WMIN, 1, WMAX, 0, ST_OVF));
		directed.push_back(row(OP_MUL, WMAX, WMAX, 1, WMAX, 0, ST_OVF));
		directed.push_back(row(OP_MUL, WMIN, 32'h100, 1, WMIN, 0, ST_OK));
		directed.push_back(row(OP_MUL, 32'h180, 32'h1, 1, 32'h2, 0, ST_OK));
		directed.push_back(row(OP_DIV, 32'h500, 32'd0, 1, WMAX, 0, ST_DIV0));
		directed.push_back(row(OP_DIV, WMIN, 32'd0, 1, WMIN, 0, ST_DIV0));
		directed.push_back(row(OP_DIV, 32'd0, 32'd0, 1, 32'd0, 0, ST_DIV0));
		directed.push_back(row(OP_DIV, WMIN, 32'hffff_ffff, 1, WMAX, 0, ST_OVF));
		directed.push_back(row(OP_GT, WMAX, WMIN, 1, 0, 1));
		directed.push_back(row(OP_LT, WMAX, WMIN, 1, 0, 0));
		directed.push_back(row(OP_GE, 32'd5, 32'd5, 1, 0, 1));
		directed.push_back(row(OP_LE, 32'd5, 32'd5, 1, 0, 1));
		directed.push_back(row(OP_LE, 32'd6, 32'd5, 1, 0, 0));
		directed.push_back(row(OP_EQ, WMIN, WMIN, 1, 0, 1));
		directed.push_back(row(OP_NE, WMIN, WMAX, 1, 0, 1));
		directed.push_back(row(OP_MIN, WMIN, WMAX, 1, WMIN));
		directed.push_back(row(OP_MAX, WMIN, WMAX, 1, WMAX));
		directed.push_back(row(OP_INC, WMAX, 32'd0, 1, WMAX, 0, ST_OVF));
		directed.push_back(row(OP_DEC, WMIN, 32'd0, 1, WMIN, 0, ST_OVF));
		directed.push_back(row(OP_DEC, 32'd0, 32'd0, 1, 32'hffff_ffff));
		directed.push_back(row(OP_FROM_INT, 32'h0080_0000, 0, 1, WMAX, 0, ST_OVF));
		directed.push_back(row(OP_TO_INT, 32'hffff_ff01, 0, 1, 32'hffff_ffff));
		directed.push_back(row(OP_DIV, 32'h0000_0100, 32'h0000_0300));
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			cur = directed[i];
			send_request(cur.op, cur.a, cur.b);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			// once midway, hold off until the pipe has drained
			if (i == N_RANDOM / 2) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			send_request(op_t'($urandom_range(0, 15)), rand_operand(), rand_operand());
		end
		s_axis_tvalid <= 1'b0;
		stim_done = 1;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY * 4) @(posedge clk);
		$display("sent %0d requests over all 16 ops, %0d results checked", n_sent, n_recv);
		$display("directed extremes, saturation and divide by zero plus random operands");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire

// ===== fixed_point_alu_q24_8.f =====
sv/fpa_pkg.sv
sv/fpa_div.sv
sv/fixed_point_alu_q24_8.sv
sv/fpa_checker.sv
test/tb_top.sv
